// File: hw/rtl/rrt_pkg.sv
package rrt_pkg;
  localparam int MaxNodes = 1024;
  localparam int IdxW = $clog2(MaxNodes);
  localparam int CntW = IdxW + 1;
  localparam int CoordW = 16;
  localparam int DiffW = CoordW + 1;
  localparam int SqW = 2 * DiffW;
  localparam int D2W = SqW + 2;
  localparam int StepW = 15;
  localparam int RootW = D2W / 2;
  localparam int ProdW = DiffW + StepW;
  localparam int RcntW = $clog2(RootW + 2);
  localparam int DcntW = $clog2(ProdW + 2);

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpExtend = 1'b1;

  typedef struct packed {
    logic start_scan;
    logic start_steer;
    logic write_node;
    logic load_direct;
  } rrt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic steer_done;
  } rrt_sts_t;
endpackage

// File: hw/rtl/rrt_ctrl.sv
module rrt_ctrl import rrt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            op,
  input  logic [CntW-1:0] node_count,
  input  rrt_sts_t        sts,
  input  logic            out_ready,
  output logic            in_ready,
  output logic            out_valid,
  output logic [1:0]      err_status,
  output logic            err_flag,
  output rrt_cmd_t        cmd
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_STEER, S_WRITE, S_OUT} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    if (state == S_IDLE && in_valid) begin
      if (node_count < CntW'(MaxNodes) && !(op == OpExtend && node_count == '0)) begin
        if (op == OpExtend) cmd.start_scan = 1'b1;
        else cmd.load_direct = 1'b1;
      end
    end
    if (state == S_SCAN && sts.scan_done) cmd.start_steer = 1'b1;
    if (state == S_WRITE) cmd.write_node = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      err_status <= StatusOk;
      err_flag <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            err_flag <= 1'b0;
            err_status <= StatusOk;
            if (node_count >= CntW'(MaxNodes)) begin
              err_flag <= 1'b1;
              err_status <= StatusFull;
              state <= S_OUT;
              out_valid <= 1'b1;
            end else if (op == OpExtend && node_count == '0) begin
              err_flag <= 1'b1;
              err_status <= StatusEmpty;
              state <= S_OUT;
              out_valid <= 1'b1;
            end else if (op == OpExtend) begin
              state <= S_SCAN;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_SCAN: if (sts.scan_done) state <= S_STEER;
        S_STEER: if (sts.steer_done) state <= S_WRITE;
        S_WRITE: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/rrt_datapath.sv
module rrt_datapath import rrt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_fire,
  input  logic signed [CoordW-1:0] sample_x,
  input  logic signed [CoordW-1:0] sample_y,
  input  logic signed [CoordW-1:0] sample_z,
  input  logic [StepW-1:0]         max_step,
  input  rrt_cmd_t                 cmd,
  output rrt_sts_t                 sts,
  output logic [CntW-1:0]          node_count,
  output logic [IdxW-1:0]          near_idx,
  output logic [IdxW-1:0]          new_idx,
  output logic signed [CoordW-1:0] new_x,
  output logic signed [CoordW-1:0] new_y,
  output logic signed [CoordW-1:0] new_z,
  output logic                     clipped
);
  logic [3*CoordW-1:0] mem [MaxNodes];
  logic [3*CoordW-1:0] rd_data;
  logic [IdxW-1:0] rd_addr;

  logic signed [CoordW-1:0] sx, sy, sz;
  logic [StepW-1:0] m;

  // Scan pipeline: address, memory read, distance, compare.
  logic scanning;
  logic [CntW-1:0] scan_ptr;
  logic rd_v, d_v;
  logic [IdxW-1:0] rd_i, d_i;
  logic [D2W-1:0] d_dist, best;
  logic have_best;
  logic signed [CoordW-1:0] bx, by, bz;

  logic signed [DiffW-1:0] ex, ey, ez;
  logic [DiffW-1:0] ax, ay, az;
  logic [SqW-1:0] qx, qy, qz;

  always_comb begin
    ex = DiffW'(sx) - DiffW'($signed(rd_data[3*CoordW-1:2*CoordW]));
    ey = DiffW'(sy) - DiffW'($signed(rd_data[2*CoordW-1:CoordW]));
    ez = DiffW'(sz) - DiffW'($signed(rd_data[CoordW-1:0]));
    ax = ex[DiffW-1] ? DiffW'(-ex) : DiffW'(ex);
    ay = ey[DiffW-1] ? DiffW'(-ey) : DiffW'(ey);
    az = ez[DiffW-1] ? DiffW'(-ez) : DiffW'(ez);
    qx = SqW'(ax) * SqW'(ax);
    qy = SqW'(ay) * SqW'(ay);
    qz = SqW'(az) * SqW'(az);
  end

  assign rd_addr = scanning ? scan_ptr[IdxW-1:0] : near_idx;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.write_node) mem[node_count[IdxW-1:0]] <= {new_x, new_y, new_z};
  end

  // Steering: if the step fits the sample is taken, else a square root, then three divides.
  typedef enum logic [2:0] {P_IDLE, P_FETCH, P_DIFF, P_D2, P_ROOT, P_DIV, P_DONE} ph_t;
  ph_t ph;
  logic signed [DiffW-1:0] dx, dy, dz;
  logic [DiffW-1:0] adx, ady, adz;
  logic [SqW-1:0] sq0, sq1, sq2;
  logic [D2W-1:0] d2, rem;
  logic [RootW-1:0] root;
  logic [RcntW-1:0] rcnt;
  logic [1:0] axis;
  logic [ProdW-1:0] num, quo;
  logic [ProdW:0] drem;
  logic [DcntW-1:0] dcnt;
  logic [ProdW:0] dtrial;
  logic [RootW-1:0] rdiv;
  logic signed [CoordW+1:0] sum;
  logic signed [CoordW-1:0] satv;
  logic neg;
  logic [D2W+1:0] rsh, rtry;

  always_comb begin
    rsh = {rem, d2[D2W-1 -: 2]};
    rtry = (D2W+2)'({root, 2'b01});
    dtrial = {drem[ProdW-1:0], num[ProdW-1]};
    rdiv = (root == '0) ? RootW'(1) : root;
    neg = (axis == 2'd0) ? dx[DiffW-1] : (axis == 2'd1) ? dy[DiffW-1] : dz[DiffW-1];
    unique case (axis)
      2'd0: sum = (CoordW+2)'(bx) + (neg ? -(CoordW+2)'(quo) : (CoordW+2)'(quo));
      2'd1: sum = (CoordW+2)'(by) + (neg ? -(CoordW+2)'(quo) : (CoordW+2)'(quo));
      default: sum = (CoordW+2)'(bz) + (neg ? -(CoordW+2)'(quo) : (CoordW+2)'(quo));
    endcase
    if (sum > (CoordW+2)'(2**(CoordW-1)-1)) satv = {1'b0, {(CoordW-1){1'b1}}};
    else if (sum < -(CoordW+2)'(2**(CoordW-1))) satv = {1'b1, {(CoordW-1){1'b0}}};
    else satv = sum[CoordW-1:0];
  end

  // The scan is finished once the last compare has left the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
    end else begin
      sts.scan_done <= have_best && !scanning && !rd_v && !d_v && ph == P_IDLE
                       && !sts.scan_done && !cmd.start_steer && !cmd.start_scan;
      sts.steer_done <= (ph == P_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= P_IDLE; scanning <= 1'b0; have_best <= 1'b0;
      rd_v <= 1'b0; d_v <= 1'b0;
    end else begin
      if (in_fire) begin
        sx <= sample_x; sy <= sample_y; sz <= sample_z; m <= max_step;
      end
      if (cmd.load_direct) begin
        near_idx <= '0; new_idx <= node_count[IdxW-1:0];
        new_x <= sample_x; new_y <= sample_y; new_z <= sample_z; clipped <= 1'b0;
      end
      rd_v <= scanning;
      rd_i <= scan_ptr[IdxW-1:0];
      d_v <= rd_v;
      d_i <= rd_i;
      d_dist <= D2W'(qx) + D2W'(qy) + D2W'(qz);
      if (cmd.start_scan) begin
        scanning <= 1'b1; scan_ptr <= '0; have_best <= 1'b0;
      end else if (scanning) begin
        if (scan_ptr == node_count - 1'b1) scanning <= 1'b0;
        scan_ptr <= scan_ptr + 1'b1;
      end
      if (d_v && (!have_best || d_dist < best)) begin
        best <= d_dist; near_idx <= d_i; have_best <= 1'b1;
      end
      unique case (ph)
        P_IDLE: if (cmd.start_steer) ph <= P_FETCH;
        P_FETCH: ph <= P_DIFF;
        P_DIFF: begin
          bx <= $signed(rd_data[3*CoordW-1:2*CoordW]);
          by <= $signed(rd_data[2*CoordW-1:CoordW]);
          bz <= $signed(rd_data[CoordW-1:0]);
          dx <= ex; dy <= ey; dz <= ez; adx <= ax; ady <= ay; adz <= az;
          ph <= P_D2;
        end
        P_D2: begin
          sq0 <= SqW'(adx) * SqW'(adx);
          sq1 <= SqW'(ady) * SqW'(ady);
          sq2 <= SqW'(adz) * SqW'(adz);
          ph <= P_ROOT; rcnt <= '0; rem <= '0; root <= '0; d2 <= '0;
        end
        P_ROOT: begin
          if (rcnt == '0) begin
            d2 <= D2W'(sq0) + D2W'(sq1) + D2W'(sq2);
            rcnt <= rcnt + 1'b1;
            have_best <= 1'b0;
          end else if (rcnt == RcntW'(1)) begin
            if (d2 <= D2W'(m) * D2W'(m)) begin
              new_x <= sx; new_y <= sy; new_z <= sz; clipped <= 1'b0;
              new_idx <= node_count[IdxW-1:0];
              ph <= P_DONE;
            end else rcnt <= rcnt + 1'b1;
          end else begin
            if (rsh >= rtry) begin
              rem <= D2W'(rsh - rtry); root <= {root[RootW-2:0], 1'b1};
            end else begin
              rem <= D2W'(rsh); root <= {root[RootW-2:0], 1'b0};
            end
            d2 <= {d2[D2W-3:0], 2'b00};
            if (rcnt == RcntW'(RootW + 1)) begin
              ph <= P_DIV; axis <= 2'd0; dcnt <= '0;
            end else rcnt <= rcnt + 1'b1;
          end
        end
        P_DIV: begin
          if (dcnt == '0) begin
            unique case (axis)
              2'd0: num <= ProdW'(adx) * ProdW'(m);
              2'd1: num <= ProdW'(ady) * ProdW'(m);
              default: num <= ProdW'(adz) * ProdW'(m);
            endcase
            drem <= '0; quo <= '0; dcnt <= dcnt + 1'b1;
          end else if (dcnt <= DcntW'(ProdW)) begin
            if (dtrial >= (ProdW+1)'(rdiv)) begin
              drem <= dtrial - (ProdW+1)'(rdiv); quo <= {quo[ProdW-2:0], 1'b1};
            end else begin
              drem <= dtrial; quo <= {quo[ProdW-2:0], 1'b0};
            end
            num <= {num[ProdW-2:0], 1'b0};
            dcnt <= dcnt + 1'b1;
          end else begin
            unique case (axis)
              2'd0: new_x <= satv;
              2'd1: new_y <= satv;
              default: new_z <= satv;
            endcase
            dcnt <= '0;
            if (axis == 2'd2) begin
              clipped <= 1'b1; new_idx <= node_count[IdxW-1:0]; ph <= P_DONE;
            end else axis <= axis + 1'b1;
          end
        end
        P_DONE: ph <= P_IDLE;
        default: ph <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) node_count <= '0;
    else if (cmd.write_node) node_count <= node_count + 1'b1;
  end
endmodule

// File: hw/rtl/rrt_nearest_extend.sv
// Load item: the node is written in S_WRITE and the result is then valid in S_OUT;
// an error item goes straight to S_OUT. Extend item: a scan over all stored nodes,
// then steering; a clipped step adds a square root and three divides.
// One item at a time; the next is taken after the result leaves.
// rst is synchronous: node count cleared, max_step set to 256, no item pending.
// Node memory contents are not cleared; only entries below node_count are read.
module rrt_nearest_extend import rrt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic signed [CoordW-1:0] sample_x,
  input  logic signed [CoordW-1:0] sample_y,
  input  logic signed [CoordW-1:0] sample_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic [IdxW-1:0]          nearest_index,
  output logic [IdxW-1:0]          new_index,
  output logic signed [CoordW-1:0] new_x,
  output logic signed [CoordW-1:0] new_y,
  output logic signed [CoordW-1:0] new_z,
  output logic                     clipped,
  input  logic                     cfg_we,
  input  logic [StepW-1:0]         cfg_wdata
);
  // The one configuration register, the step limit.
  logic [StepW-1:0] max_step;
  always_ff @(posedge clk) begin
    if (rst) max_step <= StepW'(256);
    else if (cfg_we) max_step <= cfg_wdata;
  end

  rrt_cmd_t cmd;
  rrt_sts_t sts;
  logic [CntW-1:0] node_count;
  logic [1:0] err_status;
  logic err_flag;
  logic [IdxW-1:0] near_idx, new_idx;
  logic signed [CoordW-1:0] nx, ny, nz;
  logic clip;
  logic in_fire;

  assign in_fire = in_valid && in_ready;

  // The controller sequences scan, steer and write; the datapath does the work.
  rrt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .op, .node_count, .sts, .out_ready,
    .in_ready, .out_valid, .err_status, .err_flag, .cmd
  );

  rrt_datapath u_dp (
    .clk, .rst, .in_fire, .sample_x, .sample_y, .sample_z, .max_step, .cmd, .sts,
    .node_count, .near_idx, .new_idx, .new_x(nx), .new_y(ny), .new_z(nz),
    .clipped(clip)
  );

  // Error results report zeros in every field but the status.
  assign status        = err_status;
  assign nearest_index = err_flag ? '0 : near_idx;
  assign new_index     = err_flag ? '0 : new_idx;
  assign new_x         = err_flag ? '0 : nx;
  assign new_y         = err_flag ? '0 : ny;
  assign new_z         = err_flag ? '0 : nz;
  assign clipped       = err_flag ? 1'b0 : clip;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= CntW'(MaxNodes)) else $error("node count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && err_flag) |-> $stable(node_count)) else $error("error wrote node");
endmodule
